// File: src/lottery_ticket_scheduler_core_macros.svh
// ----------------------------------------------------------------------------
// lottery scheduler assertion macros
// concurrent checks clocked on i_clk, disabled while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef LOTTERY_TICKET_SCHEDULER_CORE_MACROS_SVH
`define LOTTERY_TICKET_SCHEDULER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define LTS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("lottery scheduler check failed");
`define LTS_NEVER(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error("lottery scheduler forbidden condition");
`else
`define LTS_ASSERT(lbl, prop)
`define LTS_NEVER(lbl, expr)
`endif

`endif

// File: src/lts_pkg.sv
// ----------------------------------------------------------------------------
// lts_pkg
// shared constants, table port types and the generator step function
// ----------------------------------------------------------------------------
package lts_pkg;

    localparam int NUM_SLOTS = 64;
    localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
    localparam int SLOT_W    = 6;
    localparam int TCK_W     = 16;
    localparam int TOT_W     = 22;
    localparam int SUM_W     = (TCK_W + IDX_W > TOT_W) ? (TCK_W + IDX_W) : TOT_W;
    localparam int DIV_W     = TOT_W + 1;
    localparam int GEN_W     = 32;
    localparam int SEED_W    = 31;

    localparam logic [SUM_W-1:0] TOTAL_MAX = SUM_W'(4194303);

    localparam int SHIFT_A = 13;
    localparam int SHIFT_B = 17;
    localparam int SHIFT_C = 5;

    localparam logic ACT_UPDATE = 1'b0;
    localparam logic ACT_DRAW   = 1'b1;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic             wr_flag;
        logic [TCK_W-1:0] wr_tickets;
    } t_tbl_req;

    typedef struct packed {
        logic             flag;
        logic [TCK_W-1:0] tickets;
    } t_tbl_rsp;

    // xorshift step followed by two's complement magnitude
    function automatic logic [GEN_W-1:0] xorshift_mag(input logic [GEN_W-1:0] x_in);
        logic [GEN_W-1:0] x;
        x = x_in;
        x = x ^ (x << SHIFT_A);
        x = x ^ (x >> SHIFT_B);
        x = x ^ (x << SHIFT_C);
        if (x[GEN_W-1]) begin
            x = (~x) + GEN_W'(1);
        end
        return x;
    endfunction

endpackage

// File: src/lts_req_if.sv
// ----------------------------------------------------------------------------
// lts_req_if
// request channel: slot update or draw word
// ----------------------------------------------------------------------------
interface lts_req_if;
    logic                       valid;
    logic                       ready;
    logic                       action;
    logic [lts_pkg::SLOT_W-1:0] slot;
    logic                       runnable;
    logic [lts_pkg::TCK_W-1:0]  tickets;

    modport source (output valid, action, slot, runnable, tickets, input ready);
    modport sink   (input valid, action, slot, runnable, tickets, output ready);
endinterface

// File: src/lts_rsp_if.sv
// ----------------------------------------------------------------------------
// lts_rsp_if
// result channel: one word per draw
// ----------------------------------------------------------------------------
interface lts_rsp_if;
    logic                       valid;
    logic                       ready;
    logic                       found;
    logic [lts_pkg::SLOT_W-1:0] chosen_slot;
    logic [lts_pkg::TOT_W-1:0]  winning_number;
    logic [lts_pkg::TOT_W-1:0]  total_tickets;

    modport source (output valid, found, chosen_slot, winning_number, total_tickets,
                    input ready);
    modport sink   (input valid, found, chosen_slot, winning_number, total_tickets,
                    output ready);
endinterface

// File: src/lts_cfg_if.sv
// ----------------------------------------------------------------------------
// lts_cfg_if
// configuration write channel carrying the generator seed
// ----------------------------------------------------------------------------
interface lts_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [lts_pkg::SEED_W-1:0] seed;

    modport source (output valid, seed, input ready);
    modport sink   (input valid, seed, output ready);
endinterface

// File: src/lts_slot_table.sv
// ----------------------------------------------------------------------------
// lts_slot_table
// slot memory: runnable flag and tickets per slot, one read and one write port
// ----------------------------------------------------------------------------
module lts_slot_table (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lts_pkg::t_tbl_req i_req,
    output lts_pkg::t_tbl_rsp o_rsp
);

    localparam int ENT_W = lts_pkg::TCK_W + 1;

    logic [ENT_W-1:0]          mem [lts_pkg::NUM_SLOTS];
    logic [lts_pkg::NUM_SLOTS-1:0] r_written;
    logic [ENT_W-1:0]          r_q;
    logic                      r_q_written;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[i_req.wr_addr] <= {i_req.wr_flag, i_req.wr_tickets};
        end
        if (i_req.rd_en) begin
            r_q <= mem[i_req.rd_addr];
        end
    end

    // entries never written since reset read as empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written   <= '0;
            r_q_written <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_written[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_q_written <= r_written[i_req.rd_addr];
            end
        end
    end

    assign o_rsp.flag    = r_q_written & r_q[ENT_W-1];
    assign o_rsp.tickets = r_q_written ? r_q[lts_pkg::TCK_W-1:0] : '0;

endmodule

// File: src/lts_mod_unit.sv
// ----------------------------------------------------------------------------
// lts_mod_unit
// restoring remainder unit, one dividend bit per cycle
// ----------------------------------------------------------------------------
module lts_mod_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [lts_pkg::GEN_W-1:0]  i_dividend,
    input  logic [lts_pkg::DIV_W-1:0]  i_divisor,
    output logic                       o_done,
    output logic [lts_pkg::TOT_W-1:0]  o_rem
);

    localparam int STEP_W = $clog2(lts_pkg::GEN_W + 1);

    logic [lts_pkg::GEN_W-1:0] r_dvd;
    logic [lts_pkg::DIV_W-1:0] r_dsr;
    logic [lts_pkg::DIV_W-1:0] r_rem;
    logic [STEP_W-1:0]         r_cnt;
    logic                      r_busy;
    logic                      r_done;
    logic [lts_pkg::DIV_W:0]   shifted;
    logic [lts_pkg::DIV_W-1:0] n_rem;

    always_comb begin
        shifted = {r_rem, r_dvd[lts_pkg::GEN_W-1]};
        if (shifted >= {1'b0, r_dsr}) begin
            n_rem = lts_pkg::DIV_W'(shifted - {1'b0, r_dsr});
        end else begin
            n_rem = shifted[lts_pkg::DIV_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEP_W'(lts_pkg::GEN_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - STEP_W'(1);
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= r_dvd << 1;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[lts_pkg::TOT_W-1:0];

endmodule

// File: src/lottery_ticket_scheduler_core.sv
// ----------------------------------------------------------------------------
// lottery_ticket_scheduler_core
// lottery draw over a table of task slots with a xorshift generator
// ----------------------------------------------------------------------------
// i_req carries one word per item: an update writes one slot's runnable flag
// and tickets, a draw picks a winner. o_rsp returns one word per draw and
// nothing for an update. i_cfg loads the generator seed; write it only while
// the block is idle.
// A draw walks the slot memory twice through its single read port and runs a
// one-bit-per-cycle remainder unit in between: a first walk for the ticket
// sum, the remainder of the generator value by that sum plus one, a pick walk
// that stops at the winner, and a last step that hands over the result. The
// next item is taken once the draw is done.
// Reset clears the control state, sets the generator to 1 and marks every
// slot as empty through per-slot written flags, with no clearing pass.
// A result that is not taken stays in the output register; the block can
// still take updates, but a further draw waits at its end until that word
// has been taken.
// ----------------------------------------------------------------------------
`include "lottery_ticket_scheduler_core_macros.svh"

module lottery_ticket_scheduler_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lts_req_if.sink   i_req,
    lts_rsp_if.source o_rsp,
    lts_cfg_if.sink   i_cfg
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SUM  = 3'd1;
    localparam logic [2:0] ST_MOD  = 3'd2;
    localparam logic [2:0] ST_PICK = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    localparam int IDX_W = lts_pkg::IDX_W;
    localparam int CNT_W = lts_pkg::CNT_W;
    localparam int SUM_W = lts_pkg::SUM_W;
    localparam int TOT_W = lts_pkg::TOT_W;
    localparam int DIV_W = lts_pkg::DIV_W;

    logic [2:0]                 r_state, n_state;
    logic [lts_pkg::GEN_W-1:0]  r_gen, n_gen;
    logic [CNT_W-1:0]           r_addr, n_addr;
    logic                       r_pend, n_pend;
    logic [IDX_W-1:0]           r_rd_idx, n_rd_idx;
    logic [SUM_W-1:0]           r_acc, n_acc;
    logic [TOT_W-1:0]           r_total, n_total;
    logic [DIV_W-1:0]           r_divisor, n_divisor;
    logic [TOT_W-1:0]           r_win, n_win;
    logic                       r_hit, n_hit;
    logic [IDX_W-1:0]           r_pick, n_pick;

    logic                       r_out_vld, n_out_vld;
    logic                       r_out_found, n_out_found;
    logic [lts_pkg::SLOT_W-1:0] r_out_slot, n_out_slot;
    logic [TOT_W-1:0]           r_out_win, n_out_win;
    logic [TOT_W-1:0]           r_out_total, n_out_total;

    lts_pkg::t_tbl_req          tbl_req;
    lts_pkg::t_tbl_rsp          tbl_rsp;
    logic                       div_start;
    logic                       div_done;
    logic [TOT_W-1:0]           div_rem;

    logic                       req_fire;
    logic                       addr_done;
    logic                       slot_ok;
    logic [SUM_W-1:0]           acc_add;
    logic [TOT_W-1:0]           clamped;

    assign i_req.ready = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign req_fire    = i_req.valid && i_req.ready;
    assign addr_done   = (r_addr == CNT_W'(lts_pkg::NUM_SLOTS));
    assign slot_ok     = (32'(i_req.slot) < lts_pkg::NUM_SLOTS);
    assign acc_add     = r_acc + (tbl_rsp.flag ? SUM_W'(tbl_rsp.tickets) : '0);
    assign clamped     = (r_acc > lts_pkg::TOTAL_MAX) ? TOT_W'(lts_pkg::TOTAL_MAX)
                                                      : r_acc[TOT_W-1:0];

    lts_slot_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (tbl_req),
        .o_rsp   (tbl_rsp)
    );

    // the divisor is taken in the same cycle as the start
    lts_mod_unit u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_gen),
        .i_divisor  (n_divisor),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    always_comb begin
        n_state     = r_state;
        n_gen       = r_gen;
        n_addr      = r_addr;
        n_pend      = 1'b0;
        n_rd_idx    = r_rd_idx;
        n_acc       = r_acc;
        n_total     = r_total;
        n_divisor   = r_divisor;
        n_win       = r_win;
        n_hit       = r_hit;
        n_pick      = r_pick;
        n_out_vld   = r_out_vld && !o_rsp.ready;
        n_out_found = r_out_found;
        n_out_slot  = r_out_slot;
        n_out_win   = r_out_win;
        n_out_total = r_out_total;
        div_start   = 1'b0;

        tbl_req            = '0;
        tbl_req.rd_addr    = r_addr[IDX_W-1:0];
        tbl_req.wr_addr    = IDX_W'(i_req.slot);
        tbl_req.wr_flag    = i_req.runnable;
        tbl_req.wr_tickets = i_req.tickets;

        if (i_cfg.valid && i_cfg.ready) begin
            n_gen = lts_pkg::GEN_W'(i_cfg.seed);
        end

        case (r_state)
            ST_IDLE: begin
                if (req_fire) begin
                    if (i_req.action == lts_pkg::ACT_UPDATE) begin
                        tbl_req.wr_en = slot_ok;
                    end else begin
                        n_gen   = lts_pkg::xorshift_mag(r_gen);
                        n_addr  = '0;
                        n_acc   = '0;
                        n_state = ST_SUM;
                    end
                end
            end
            ST_SUM: begin
                if (!addr_done) begin
                    tbl_req.rd_en = 1'b1;
                    n_pend        = 1'b1;
                    n_rd_idx      = r_addr[IDX_W-1:0];
                    n_addr        = r_addr + CNT_W'(1);
                end
                if (r_pend) begin
                    n_acc = acc_add;
                end
                // all data in: clamp and start the remainder
                if (addr_done && !r_pend) begin
                    n_total   = clamped;
                    n_divisor = DIV_W'(clamped) + DIV_W'(1);
                    div_start = 1'b1;
                    n_state   = ST_MOD;
                end
            end
            ST_MOD: begin
                if (div_done) begin
                    n_win   = div_rem;
                    n_addr  = '0;
                    n_acc   = '0;
                    n_hit   = 1'b0;
                    n_pick  = '0;
                    n_state = ST_PICK;
                end
            end
            ST_PICK: begin
                if (!addr_done) begin
                    tbl_req.rd_en = 1'b1;
                    n_pend        = 1'b1;
                    n_rd_idx      = r_addr[IDX_W-1:0];
                    n_addr        = r_addr + CNT_W'(1);
                end
                if (r_pend) begin
                    n_acc = acc_add;
                    if (tbl_rsp.flag && (acc_add >= SUM_W'(r_win))) begin
                        // winner found: clear the slot's runnable flag and keep its tickets
                        n_hit              = 1'b1;
                        n_pick             = r_rd_idx;
                        tbl_req.wr_en      = 1'b1;
                        tbl_req.wr_addr    = r_rd_idx;
                        tbl_req.wr_flag    = 1'b0;
                        tbl_req.wr_tickets = tbl_rsp.tickets;
                        n_pend             = 1'b0;
                        n_state            = ST_FIN;
                    end
                end
                if (addr_done && !r_pend) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!r_out_vld || o_rsp.ready) begin
                    n_out_vld   = 1'b1;
                    n_out_found = r_hit;
                    n_out_slot  = r_hit ? lts_pkg::SLOT_W'(r_pick) : '0;
                    n_out_win   = r_win;
                    n_out_total = r_total;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_gen     <= lts_pkg::GEN_W'(1);
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_gen     <= n_gen;
            r_pend    <= n_pend;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr      <= n_addr;
        r_rd_idx    <= n_rd_idx;
        r_acc       <= n_acc;
        r_total     <= n_total;
        r_divisor   <= n_divisor;
        r_win       <= n_win;
        r_hit       <= n_hit;
        r_pick      <= n_pick;
        r_out_found <= n_out_found;
        r_out_slot  <= n_out_slot;
        r_out_win   <= n_out_win;
        r_out_total <= n_out_total;
    end

    assign o_rsp.valid          = r_out_vld;
    assign o_rsp.found          = r_out_found;
    assign o_rsp.chosen_slot    = r_out_slot;
    assign o_rsp.winning_number = r_out_win;
    assign o_rsp.total_tickets  = r_out_total;

    `LTS_ASSERT(a_win_below_divisor, (r_state == ST_PICK) |-> ({1'b0, r_win} < r_divisor))
    `LTS_ASSERT(a_none_slot_zero, (r_out_vld && !r_out_found) |-> (r_out_slot == '0))
    `LTS_NEVER(a_wr_only_idle_pick, tbl_req.wr_en && (r_state != ST_IDLE) && (r_state != ST_PICK))
    `LTS_ASSERT(a_div_done_in_mod, div_done |-> (r_state == ST_MOD))

endmodule
